>>> sv/ira_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ira_pkg: shared types for the interval room allocator
// Booking and result payload structs.
// ----------------------------------------------------------------------------
package ira_pkg;

  typedef struct packed {
    logic [31:0] arrival;
    logic [31:0] departure;
    logic [15:0] request_id;
  } booking_t;

  typedef struct packed {
    logic [10:0] room;
    logic [10:0] rooms_used;
    logic [15:0] tag_out;
    logic        overflow;
  } result_t;

endpackage

>>> sv/interval_room_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_room_allocator
// Greedy interval partitioning: heap of busy rooms, FIFO of freed rooms.
// ----------------------------------------------------------------------------
// A booking is taken only when the block is idle and the result register is
// empty or being drained. Each booking first retires every heap entry whose
// departure is earlier than the arrival: each retire is a root read and a
// check plus a sift-down that, per level visited, reads the left child,
// compares and reads the right child, then compares and moves. The push then
// sifts up, reading the parent and comparing at each level. One compare unit
// and one single-port heap memory do all the work, so these steps run one at
// a time; each sift visits at most about log2(MAX_ROOMS) levels. A booking on
// a full heap is dropped with an overflow result after its retires. The next
// booking can transfer in the cycle after its result is loaded. Memories need
// no clearing after reset.
module interval_room_allocator
  import ira_pkg::*;
#(
  parameter int MAX_ROOMS = 1024,
  parameter int TIME_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  booking_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output result_t  out_data_o
);

  localparam int AW = $clog2(MAX_ROOMS);
  localparam int CW = AW + 1;
  localparam int RW = 11;
  localparam int EW = TIME_BITS + CW;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ROOT  = 10'b0000000010,
    S_CHK   = 10'b0000000100,
    S_DNRD  = 10'b0000001000,
    S_DNL   = 10'b0000010000,
    S_DNR   = 10'b0000100000,
    S_ALLOC = 10'b0001000000,
    S_FTAKE = 10'b0010000000,
    S_UPRD  = 10'b0100000000,
    S_UPCMP = 10'b1000000000
  } state_e;

  state_e state_q;

  // heap and free room FIFO storage
  logic [EW-1:0] heap_mem [MAX_ROOMS];
  logic [CW-1:0] fifo_mem [MAX_ROOMS];

  logic [CW-1:0] heap_cnt_q, fcnt_q, opened_q;
  logic [AW-1:0] fhead_q, ftail_q;
  logic [TIME_BITS-1:0] arr_q, dep_q;
  logic [15:0] tag_q;
  logic [EW-1:0] rd_q, last_q, best_q, ins_q;
  logic [CW-1:0] idx_q, bidx_q;
  logic [CW-1:0] room_q;
  logic [CW-1:0] frd_q;
  logic          ovalid_q;
  result_t       odata_q;

  // shared compare unit: a < b on (departure, room)
  logic [EW-1:0] cmp_a, cmp_b;
  logic          cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  logic out_free;
  assign out_free    = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  logic [CW:0] lchild, rchild, parent;
  assign lchild = {idx_q, 1'b0} + (CW+1)'(1);
  assign rchild = {idx_q, 1'b0} + (CW+1)'(2);
  assign parent = (CW+1)'((idx_q - CW'(1)) >> 1);

  always_comb begin
    cmp_a = rd_q;
    cmp_b = best_q;
    unique case (state_q)
      S_UPCMP: begin cmp_a = ins_q;  cmp_b = rd_q;  end
      default: begin cmp_a = rd_q;   cmp_b = best_q; end
    endcase
  end

  logic [TIME_BITS-1:0] rd_dep;
  assign rd_dep = rd_q[EW-1 -: TIME_BITS];

  // status terms of the sequencer
  logic pop_go, l_ok, r_ok, heap_full;
  assign pop_go    = (heap_cnt_q != '0) && (rd_dep < arr_q);
  assign l_ok      = lchild < (CW+1)'(heap_cnt_q);
  assign r_ok      = rchild < (CW+1)'(heap_cnt_q);
  assign heap_full = heap_cnt_q >= CW'(MAX_ROOMS);

  // moving entry of a sift-down: the last entry is read into rd_q at the start
  logic [EW-1:0] mv;
  assign mv = (idx_q == '0) ? rd_q : last_q;

  // sift-down choice between the moving entry and both children
  logic [CW-1:0] dn_m;
  logic [EW-1:0] dn_b;
  always_comb begin
    dn_m = bidx_q;
    dn_b = best_q;
    if (r_ok && cmp_lt) begin
      dn_m = CW'(rchild);
      dn_b = rd_q;
    end
  end

  logic res_set;
  assign res_set = (state_q == S_ALLOC && heap_full) ||
                   (state_q == S_UPRD && idx_q == '0) ||
                   (state_q == S_UPCMP && !cmp_lt);

  // memory port controls, one heap access per cycle
  logic          heap_re, heap_we, fifo_we, fifo_re;
  logic [AW-1:0] heap_raddr, heap_waddr;
  logic [EW-1:0] heap_wdata;
  always_comb begin
    heap_re    = 1'b0;
    heap_raddr = '0;
    heap_we    = 1'b0;
    heap_waddr = AW'(idx_q);
    heap_wdata = ins_q;
    fifo_we    = 1'b0;
    fifo_re    = 1'b0;
    unique case (state_q)
      S_ROOT: heap_re = 1'b1;
      S_CHK: begin
        heap_re    = pop_go;
        heap_raddr = AW'(heap_cnt_q - CW'(1));
        fifo_we    = pop_go && (fcnt_q < CW'(MAX_ROOMS));
      end
      S_DNRD: begin
        heap_re    = l_ok;
        heap_raddr = AW'(lchild);
      end
      S_DNL: begin
        heap_re    = r_ok;
        heap_raddr = AW'(rchild);
      end
      S_DNR: begin
        heap_we    = heap_cnt_q != '0;
        heap_wdata = (dn_m == idx_q) ? last_q : dn_b;
      end
      S_ALLOC: fifo_re = !heap_full && (fcnt_q != '0);
      S_UPRD: begin
        heap_re    = idx_q != '0;
        heap_raddr = AW'(parent);
        heap_we    = idx_q == '0;
      end
      S_UPCMP: begin
        heap_we    = 1'b1;
        heap_wdata = cmp_lt ? rd_q : ins_q;
      end
      default: begin
      end
    endcase
  end

  // heap and fifo memories with registered read data
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    if (heap_re) rd_q <= heap_mem[heap_raddr];
    if (fifo_we) fifo_mem[ftail_q] <= rd_q[CW-1:0];
    if (fifo_re) frd_q <= fifo_mem[fhead_q];
  end

  // result valid: set when a result is loaded, cleared on its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (res_set) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      heap_cnt_q <= '0;
      fcnt_q     <= '0;
      opened_q   <= '0;
      fhead_q    <= '0;
      ftail_q    <= '0;
      arr_q      <= '0;
      dep_q      <= '0;
      tag_q      <= '0;
      last_q     <= '0;
      best_q     <= '0;
      ins_q      <= '0;
      idx_q      <= '0;
      bidx_q     <= '0;
      room_q     <= '0;
      odata_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && out_free) begin
            arr_q   <= TIME_BITS'(in_data_i.arrival);
            dep_q   <= TIME_BITS'(in_data_i.departure);
            tag_q   <= in_data_i.request_id;
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (pop_go) begin
            // retire root: room to fifo, last entry is read for sift-down
            if (fcnt_q < CW'(MAX_ROOMS)) begin
              ftail_q <= (ftail_q == AW'(MAX_ROOMS-1)) ? '0 : ftail_q + AW'(1);
              fcnt_q  <= fcnt_q + CW'(1);
            end
            heap_cnt_q <= heap_cnt_q - CW'(1);
            idx_q      <= '0;
            state_q    <= S_DNRD;
          end else begin
            state_q <= S_ALLOC;
          end
        end
        S_DNRD: begin
          // best starts as the moving entry
          best_q  <= mv;
          last_q  <= mv;
          bidx_q  <= idx_q;
          state_q <= S_DNL;
        end
        S_DNL: begin
          if (l_ok && cmp_lt) begin
            best_q <= rd_q;
            bidx_q <= CW'(lchild);
          end
          state_q <= S_DNR;
        end
        S_DNR: begin
          if (heap_cnt_q == '0 || dn_m == idx_q) begin
            state_q <= S_ROOT;
          end else begin
            idx_q   <= dn_m;
            state_q <= S_DNRD;
          end
        end
        S_ALLOC: begin
          if (heap_full) begin
            odata_q.room       <= '0;
            odata_q.rooms_used <= RW'(opened_q);
            odata_q.tag_out    <= tag_q;
            odata_q.overflow   <= 1'b1;
            state_q            <= S_IDLE;
          end else begin
            if (fcnt_q == '0) begin
              room_q   <= opened_q + CW'(1);
              opened_q <= opened_q + CW'(1);
            end else begin
              room_q  <= '0;
              fhead_q <= (fhead_q == AW'(MAX_ROOMS-1)) ? '0 : fhead_q + AW'(1);
              fcnt_q  <= fcnt_q - CW'(1);
            end
            state_q <= S_FTAKE;
          end
        end
        S_FTAKE: begin
          ins_q      <= {dep_q, ((room_q != '0) ? room_q : frd_q)};
          idx_q      <= heap_cnt_q;
          heap_cnt_q <= heap_cnt_q + CW'(1);
          state_q    <= S_UPRD;
        end
        S_UPRD: begin
          if (idx_q != '0) begin
            state_q <= S_UPCMP;
          end else begin
            odata_q.room       <= RW'(ins_q[CW-1:0]);
            odata_q.rooms_used <= RW'(opened_q);
            odata_q.tag_out    <= tag_q;
            odata_q.overflow   <= 1'b0;
            state_q            <= S_IDLE;
          end
        end
        S_UPCMP: begin
          if (cmp_lt) begin
            idx_q   <= CW'(parent);
            state_q <= S_UPRD;
          end else begin
            odata_q.room       <= RW'(ins_q[CW-1:0]);
            odata_q.rooms_used <= RW'(opened_q);
            odata_q.tag_out    <= tag_q;
            odata_q.overflow   <= 1'b0;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ira_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ira_checker
// Port-level checks for the interval room allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ira_checker
  import ira_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_o,
  input logic    out_valid_o,
  input logic    out_ready_i,
  input result_t out_data_o
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // an input transfer blocks further input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after transfer");

  // overflow results carry room zero, others a nonzero room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.overflow == (out_data_o.room == '0)))
    else $error("room and overflow disagree");

  // assigned room never exceeds rooms opened
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.room <= out_data_o.rooms_used)
    else $error("room beyond rooms used");

endmodule

bind interval_room_allocator ira_checker u_ira_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> verif/interval_room_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_room_allocator_tb: self-checking bench for the room allocator
// Drives bookings over valid/ready, predicts rooms with an own heap and free
// list, and compares every result transfer in order against the prediction.
// ----------------------------------------------------------------------------
module interval_room_allocator_tb;
  import ira_pkg::*;

  localparam int ROOMS = 1024;
  localparam int EXP_DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 200000;

  // room predictor and expected-result store
  class room_scoreboard;
    logic [31:0] heap_dep[ROOMS];
    logic [10:0] heap_room[ROOMS];
    int heap_n;
    logic [10:0] free_buf[ROOMS];
    int free_rd, free_wr, free_n;
    logic [10:0] opened;
    result_t exp_buf[EXP_DEPTH];
    int exp_rd, exp_wr;
    int pending_n;
    int errors;

    function void clear();
      heap_n = 0;
      free_rd = 0;
      free_wr = 0;
      free_n = 0;
      opened = '0;
      exp_rd = 0;
      exp_wr = 0;
      pending_n = 0;
      errors = 0;
    endfunction

    function void free_put(logic [10:0] rm);
      free_buf[free_wr] = rm;
      free_wr = (free_wr + 1) % ROOMS;
      free_n++;
    endfunction

    function logic [10:0] free_take();
      logic [10:0] rm;
      rm = free_buf[free_rd];
      free_rd = (free_rd + 1) % ROOMS;
      free_n--;
      return rm;
    endfunction

    function void exp_put(result_t res);
      exp_buf[exp_wr] = res;
      exp_wr = (exp_wr + 1) % EXP_DEPTH;
      pending_n++;
    endfunction

    function result_t exp_take();
      result_t res;
      res = exp_buf[exp_rd];
      exp_rd = (exp_rd + 1) % EXP_DEPTH;
      pending_n--;
      return res;
    endfunction

    function bit is_less(logic [31:0] da, logic [10:0] ra, logic [31:0] db, logic [10:0] rb);
      if (da != db) return da < db;
      return ra < rb;
    endfunction

    function void pop_root();
      int i, l, r, m;
      logic [31:0] ld;
      logic [10:0] lr;
      i = 0;
      heap_n--;
      if (heap_n == 0) return;
      ld = heap_dep[heap_n];
      lr = heap_room[heap_n];
      forever begin
        logic [31:0] bd;
        logic [10:0] br;
        l = 2 * i + 1;
        r = l + 1;
        m = i;
        bd = ld;
        br = lr;
        if (l < heap_n && is_less(heap_dep[l], heap_room[l], bd, br)) begin
          m = l;
          bd = heap_dep[l];
          br = heap_room[l];
        end
        if (r < heap_n && is_less(heap_dep[r], heap_room[r], bd, br)) m = r;
        if (m == i) break;
        heap_dep[i] = heap_dep[m];
        heap_room[i] = heap_room[m];
        i = m;
      end
      heap_dep[i] = ld;
      heap_room[i] = lr;
    endfunction

    function void push(logic [31:0] d, logic [10:0] rm);
      int i, p;
      i = heap_n;
      heap_n++;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!is_less(d, rm, heap_dep[p], heap_room[p])) break;
        heap_dep[i] = heap_dep[p];
        heap_room[i] = heap_room[p];
        i = p;
      end
      heap_dep[i] = d;
      heap_room[i] = rm;
    endfunction

    // note an accepted booking and queue its expected result
    function void note_booking(booking_t b);
      result_t res;
      while (heap_n > 0 && heap_dep[0] < b.arrival) begin
        free_put(heap_room[0]);
        pop_root();
      end
      res.tag_out = b.request_id;
      if (heap_n >= ROOMS) begin
        res.room = '0;
        res.rooms_used = opened;
        res.overflow = 1'b1;
      end else begin
        if (free_n == 0) begin
          opened++;
          free_put(opened);
        end
        res.room = free_take();
        res.rooms_used = opened;
        res.overflow = 1'b0;
        push(b.departure, res.room);
      end
      exp_put(res);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    // check one result transfer against the oldest expectation
    task check_result(result_t got);
      result_t want;
      if (pending_n == 0) begin
        report("unexpected result, tag", got.tag_out, -1);
        return;
      end
      want = exp_take();
      if (got.room != want.room) report("room", got.room, want.room);
      if (got.rooms_used != want.rooms_used)
        report("rooms_used", got.rooms_used, want.rooms_used);
      if (got.tag_out != want.tag_out) report("tag_out", got.tag_out, want.tag_out);
      if (got.overflow != want.overflow) report("overflow", got.overflow, want.overflow);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  booking_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  result_t out_data_o;

  room_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;
  int quiet_cycles = 0;
  logic [31:0] now_arr = '0;

  always #5 clk_i = ~clk_i;

  interval_room_allocator u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // receiver: random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // offer one booking and hold it until the transfer
  task send_booking(logic [31:0] arr, logic [31:0] dep, logic [15:0] id);
    booking_t b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    b.arrival = arr;
    b.departure = dep;
    b.request_id = id;
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_booking(b);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_n != 0) @(posedge clk_i);
  endtask

  // random booking, mostly ordered arrivals with short stays
  task send_random();
    logic [31:0] dep;
    int k;
    k = $urandom_range(99);
    if (k < 85) now_arr = now_arr + $urandom_range(3);
    else if (k < 90) now_arr = now_arr - $urandom_range(5);
    else if (k < 93) now_arr = $urandom;
    k = $urandom_range(99);
    if (k < 80) dep = now_arr + $urandom_range(20);
    else if (k < 90) dep = now_arr - $urandom_range(3);
    else dep = $urandom;
    send_booking(now_arr, dep, 16'($urandom));
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, equal departures, departure below arrival
    send_booking(32'd0, 32'd0, 16'h0000);
    send_booking(32'd0, 32'd5, 16'hffff);
    send_booking(32'd0, 32'd5, 16'h5555);
    send_booking(32'd6, 32'd6, 16'haaaa);
    send_booking(32'd10, 32'd3, 16'h0001);
    send_booking(32'd11, 32'd11, 16'h0002);
    send_booking(32'd5, 32'd7, 16'h0003);
    send_booking(32'hffff_fff0, 32'hffff_ffff, 16'h0004);
    send_booking(32'hffff_ffff, 32'hffff_ffff, 16'h0005);
    send_booking(32'hffff_ffff, 32'h0000_0000, 16'h0006);
    send_booking(32'h0000_0000, 32'hffff_ffff, 16'h0007);
    drain();

    // fill the heap to capacity, then overflow, with the receiver held off
    now_arr = 32'd0;
    recv_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      begin
        for (int i = 0; i < ROOMS + 4; i++)
          send_booking(32'h0, 32'hffff_fffe, i[15:0]);
      end
    join
    drain();
    // free everything at once
    send_booking(32'hffff_ffff, 32'hffff_ffff, 16'h1234);
    drain();
    // back to small times: the heap holds one long entry
    now_arr = 32'hffff_ffff;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int i = 0; i < 80; i++) send_random();
      // sender pauses until every result is back
      drain();
      repeat ($urandom_range(60)) @(posedge clk_i);
      for (int i = 0; i < 20; i++) send_random();
    end
    send_idle_pct = 10;
    recv_stall_pct = 10;
    for (int i = 0; i < 10; i++) send_random();

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_n == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ira_pkg.sv
sv/interval_room_allocator.sv
sv/ira_checker.sv
verif/interval_room_allocator_tb.sv
